FILE: rtl/pemrv_pkg.sv
package pemrv_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int FRAC_BITS_DEF    = 16;

   typedef struct packed {
      logic [9:0]         elem_index;
      logic signed [31:0] sample_value;
      logic               new_vector;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mean_value;
      logic [62:0]        variance_value;
      logic [31:0]        samples_seen;
      logic               index_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIVM,
      ST_MEAN,
      ST_NDEV,
      ST_MUL0,
      ST_MUL1,
      ST_ACC0,
      ST_ACC1,
      ST_DIVV,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/per_element_running_mean_variance.sv
// Response path: an out-of-range index and a sample of the first vector go
//   from IDLE straight to RESP; a Welford update runs READ through DIVV to RESP.
// Throughput: one transaction at a time; the shared 1-bit/cycle divider runs
//   33 steps for the mean and 64 steps for the variance on every update.
// Reset (synchronous, active high) clears the count and sets element_count
//   to 1, then busy stays high while the squared deviation memory is swept
//   to zero. The receiver cannot stall results.
module per_element_running_mean_variance #(
   parameter int MAX_ELEMENTS = pemrv_pkg::MAX_ELEMENTS_DEF,
   parameter int FRAC_BITS    = pemrv_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pemrv_pkg::req_type req_data,
   output logic               rsp_valid,
   output pemrv_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_wr_data
);
   import pemrv_pkg::*;

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam logic [16:0] MAX_LIM = 17'(MAX_ELEMENTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

   // state memories
   logic signed [31:0] mean_mem [MAX_ELEMENTS];
   logic [63:0]        sqdev_mem [MAX_ELEMENTS];

   state_type state_ff, state_in;
   logic [10:0]   ecount_ff, ecount_in;
   logic [31:0]   count_ff, count_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [31:0] x_ff, x_in;
   logic          err_ff, err_in;
   logic          first_ff, first_in;
   logic          neg_ff, neg_in;
   logic [32:0]   a_ff, a_in;
   logic [32:0]   b_ff, b_in;
   logic [49:0]   p_ff, p_in;
   logic [49:0]   acc_ff, acc_in;
   logic [63:0]   prod_ff, prod_in;
   logic signed [31:0] mnew_ff, mnew_in;
   // shared restoring divider
   logic [63:0]   dq_ff, dq_in;
   logic [31:0]   drem_ff, drem_in;
   logic [31:0]   dd_ff, dd_in;
   logic [6:0]    dcnt_ff, dcnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic signed [31:0] mean_rd_ff;
   logic [63:0]        sq_rd_ff;

   logic          mean_we;
   logic          sq_we;
   logic [AW-1:0] sq_waddr;
   logic [63:0]   sq_wdata;

   logic [16:0]   limit;
   logic          idx_err;
   logic [31:0]   n_next;
   logic [32:0]   dshift;
   logic [33:0]   ddiff;
   logic [32:0]   dev;
   logic [32:0]   ndev;
   logic [33:0]   msum;
   logic [33:0]   qterm;
   logic [63:0]   pfull;
   logic [64:0]   ssum;
   logic [63:0]   sum_sat;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      limit   = ({6'd0, ecount_ff} > MAX_LIM) ? MAX_LIM : {6'd0, ecount_ff};
      idx_err = ({7'd0, req_data.elem_index} >= limit);
      n_next  = (req_data.new_vector && (count_ff != '1)) ? count_ff + 32'd1 : count_ff;
      dshift  = {drem_ff, dq_ff[63]};
      ddiff   = {1'b0, dshift} - {2'b00, dd_ff};
      dev     = {x_ff[31], x_ff} - {mean_rd_ff[31], mean_rd_ff};
      ndev    = {x_ff[31], x_ff} - {mnew_ff[31], mnew_ff};
      qterm   = neg_ff ? (34'd0 - {1'b0, dq_ff[32:0]}) : {1'b0, dq_ff[32:0]};
      msum    = {{2{mean_rd_ff[31]}}, mean_rd_ff} + qterm;
      pfull   = {14'd0, acc_ff} + {p_ff[46:0], 17'd0};
      ssum    = {1'b0, sq_rd_ff} + {1'b0, prod_ff};
      sum_sat = ssum[64] ? '1 : ssum[63:0];
   end

   always_comb begin
      state_in     = state_ff;
      ecount_in    = csr_wr_en ? csr_wr_data : ecount_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      err_in       = err_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      mnew_in      = mnew_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      dd_in        = dd_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mean_we      = 1'b0;
      sq_we        = 1'b0;
      sq_waddr     = addr_ff;
      sq_wdata     = sum_sat;

      if (state_ff == ST_DIVM || state_ff == ST_DIVV) begin
         dcnt_in = dcnt_ff - 7'd1;
         dq_in   = {dq_ff[62:0], !ddiff[33]};
         drem_in = ddiff[33] ? dshift[31:0] : ddiff[31:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            sq_we       = 1'b1;
            sq_waddr    = clr_addr_ff;
            sq_wdata    = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               addr_in = AW'(req_data.elem_index);
               x_in    = req_data.sample_value;
               err_in  = idx_err;
               if (idx_err) begin
                  first_in = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  count_in = n_next;
                  first_in = (n_next <= 32'd1);
                  state_in = (n_next <= 32'd1) ? ST_RESP : ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            neg_in  = dev[32];
            a_in    = dev[32] ? (33'd0 - dev) : dev;
            dq_in   = {(dev[32] ? (33'd0 - dev) : dev), 31'd0};
            drem_in = '0;
            dd_in   = count_ff;
            dcnt_in = 7'd33;
            state_in = ST_DIVM;
         end
         ST_DIVM: begin
            if (dcnt_ff == 7'd1) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            mnew_in  = msum[31:0];
            state_in = ST_NDEV;
         end
         ST_NDEV: begin
            b_in     = ndev[32] ? (33'd0 - ndev) : ndev;
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            p_in     = a_ff * {16'd0, b_ff[16:0]};
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in   = p_ff;
            p_in     = a_ff * {17'd0, b_ff[32:17]};
            state_in = ST_ACC0;
         end
         ST_ACC0: begin
            prod_in  = pfull >> FRAC_BITS;
            state_in = ST_ACC1;
         end
         ST_ACC1: begin
            sq_we    = 1'b1;
            dq_in    = sum_sat;
            drem_in  = '0;
            dd_in    = count_ff - 32'd1;
            dcnt_in  = 7'd64;
            state_in = ST_DIVV;
         end
         ST_DIVV: begin
            if (dcnt_ff == 7'd1) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_in.samples_seen = count_ff;
            rsp_in.index_error  = err_ff;
            if (err_ff) begin
               rsp_in.mean_value     = '0;
               rsp_in.variance_value = '0;
            end else if (first_ff) begin
               mean_we = 1'b1;
               rsp_in.mean_value     = x_ff;
               rsp_in.variance_value = '0;
            end else begin
               mean_we = 1'b1;
               rsp_in.mean_value     = mnew_ff;
               rsp_in.variance_value = dq_ff[63] ? '1 : dq_ff[62:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ecount_ff    <= 11'd1;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ecount_ff    <= ecount_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff  <= addr_in;
      x_ff     <= x_in;
      err_ff   <= err_in;
      first_ff <= first_in;
      neg_ff   <= neg_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      mnew_ff  <= mnew_in;
      dq_ff    <= dq_in;
      drem_ff  <= drem_in;
      dd_ff    <= dd_in;
      dcnt_ff  <= dcnt_in;
      rsp_ff   <= rsp_in;
   end

   // mean memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (mean_we) begin
         mean_mem[addr_ff] <= (first_ff ? x_ff : mnew_ff);
      end
      mean_rd_ff <= mean_mem[addr_ff];
   end

   // squared deviation memory: clear sweep or update write, registered read
   always_ff @(posedge clock) begin
      if (sq_we) begin
         sqdev_mem[sq_waddr] <= sq_wdata;
      end
      sq_rd_ff <= sqdev_mem[addr_ff];
   end

endmodule

FILE: rtl/pemrv_checker.sv
module pemrv_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input pemrv_pkg::rsp_type rsp_data
);
   import pemrv_pkg::*;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after accept");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy) else $error("no clearing sweep after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.index_error) |->
         (rsp_data.mean_value == 0 && rsp_data.variance_value == 0))
      else $error("index error with nonzero payload");

   a_var_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.samples_seen <= 1) |-> (rsp_data.variance_value == 0))
      else $error("variance nonzero on first vector");

endmodule

bind per_element_running_mean_variance pemrv_checker u_pemrv_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/pemrv_checker.sv
module pemrv_tb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  pemrv_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  pemrv_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [10:0]        csr_wr_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import pemrv_pkg::*;

   localparam int NELEM = MAX_ELEMENTS_DEF;
   localparam int FRAC  = FRAC_BITS_DEF;

   logic [10:0]        elem_limit;
   logic signed [31:0] mean_mem [NELEM];
   logic [63:0]        sqdev_mem [NELEM];
   logic [31:0]        n_vectors;
   rsp_type            expected_q [$];

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Welford update for one sample transaction
   function automatic rsp_type welford_update(input req_type rq);
      rsp_type             r;
      logic signed [63:0]  x, m_old, m_new, dev, ndev, n;
      logic [63:0]         prod, sum, var_q;
      logic [10:0]         lim;
      r = '0;
      x = rq.sample_value;
      lim = (elem_limit > NELEM) ? NELEM[10:0] : elem_limit;
      if ({1'b0, rq.elem_index} >= lim) begin
         r.samples_seen = n_vectors;
         r.index_error  = 1'b1;
         return r;
      end
      if (rq.new_vector && n_vectors != 32'hFFFF_FFFF) n_vectors++;
      var_q = 0;
      if (n_vectors <= 1) begin
         m_new = x;
      end else begin
         n     = {32'd0, n_vectors};
         m_old = mean_mem[rq.elem_index];
         dev   = x - m_old;
         m_new = m_old + dev / n;
         ndev  = x - m_new;
         prod  = (abs64(dev) * abs64(ndev)) >> FRAC;
         sum   = sqdev_mem[rq.elem_index] + prod;
         if (sum < prod) sum = '1;
         sqdev_mem[rq.elem_index] = sum;
         var_q = sum / {32'd0, n_vectors - 32'd1};
         if (var_q[63]) var_q = 64'h7FFF_FFFF_FFFF_FFFF;
      end
      mean_mem[rq.elem_index] = m_new[31:0];
      r.mean_value     = m_new[31:0];
      r.variance_value = var_q[62:0];
      r.samples_seen   = n_vectors;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         elem_limit = 11'd1;
         n_vectors  = 0;
         for (int i = 0; i < NELEM; i++) begin
            sqdev_mem[i] = 0;
            mean_mem[i]  = 0;
         end
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t mismatch: expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            e = welford_update(req_data);
            expected_q = {expected_q, e};
         end
         if (csr_wr_en) elem_limit = csr_wr_data;
      end
      pending_count = expected_q.size();
   end
endmodule

FILE: tb/sv/tb_per_element_running_mean_variance.sv
module tb_per_element_running_mean_variance;
   timeunit 1ns;
   timeprecision 1ps;

   import pemrv_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_wr_en = 0;
   logic [10:0] csr_wr_data = '0;
   int          fail_count;
   int          pending_count;

   per_element_running_mean_variance dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   pemrv_tb_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Worst case: ~1350 updates plus idle gaps, well within this timeout.
   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // Number of elements in the current setting.
   int n_elem;

   // Send one transaction; idle gap beforehand, mostly short, sometimes long.
   task automatic send_sample(input logic [9:0] idx, input logic [31:0] val,
                              input logic nv);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
          : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
      repeat (gap) @(posedge clock);
      start    <= 1'b1;
      req_data <= '{elem_index: idx, sample_value: val, new_vector: nv};
      do @(posedge clock); while (busy);
      start    <= 1'b0;
   endtask

   // Wait for all expected results and an idle block, then let it settle.
   task automatic drain();
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count(input logic [10:0] cnt);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cnt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      n_elem = (cnt > 1024) ? 1024 : cnt;
   endtask

   // Random sample: mostly moderate values, some at the extremes.
   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 400000)) - 200000);
      endcase
   endfunction

   // One full vector, every element in order; index noise now and then.
   task automatic send_vector();
      for (int i = 0; i < n_elem; i++) begin
         if ($urandom_range(0, 15) == 0)
            send_sample(10'($urandom_range(n_elem, 1023)), $urandom(),
                        1'($urandom_range(0, 1)));
         send_sample(10'(i), rand_sample(), i == 0);
      end
   endtask

   int sent;

   initial begin
      n_elem = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Count above MAX_ELEMENTS: index 1023 is in range. Written while n is
      // still zero, so these elements are never read before being written.
      write_count(11'd2047);
      send_sample(10'd1023, 32'h5555_AAAA, 1'b0);
      send_sample(10'd512, 32'hAAAA_5555, 1'b0);
      write_count(11'd1);

      // Directed: sample before any vector flag, element count of one
      send_sample(10'd0, 32'h7FFF_FFFF, 1'b0);
      send_sample(10'd1, 32'h1234_5678, 1'b1);      // out of range, flag ignored
      send_sample(10'd1023, 32'h8000_0000, 1'b0);   // out of range
      send_sample(10'd0, 32'h8000_0000, 1'b1);
      send_sample(10'd0, 32'h7FFF_FFFF, 1'b1);
      send_sample(10'd0, 32'h8000_0000, 1'b1);
      send_sample(10'd0, 32'h0000_0000, 1'b0);
      send_sample(10'd0, 32'hFFFF_FFFF, 1'b1);

      // Zero element count: everything out of range.
      write_count(11'd0);
      send_sample(10'd0, 32'h1, 1'b1);
      send_sample(10'd1023, 32'hFFFF_FFFF, 1'b1);
      drain();

      // Random phases: fresh reset not possible, so element sets stay
      // within those first written at n <= 1 (element 0 always written).
      sent = 0;
      write_count(11'd1);
      while (sent < 300) begin send_vector(); sent += n_elem; end
      write_count(11'd0);
      for (int k = 0; k < 20; k++)
         send_sample(10'($urandom()), $urandom(), 1'($urandom_range(0, 1)));
      write_count(11'd1);
      while (sent < 1350) begin send_vector(); sent += n_elem; end

      drain();
      repeat (120) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
